[hw/rtl/gvna_pkg.sv]
// ----------------------------------------------------------------------------
// gvna_pkg: shared constants and types for the grid vertex normal averager
// Field widths, arithmetic widths of the serial datapath and the request and
// result words passed between the top level and the normalizer.
// ----------------------------------------------------------------------------
`default_nettype none
package gvna_pkg;

  localparam int DEF_MAX_ROW = 1024;
  localparam int CFG_W       = 11;
  localparam int GRID_RESET  = 257;
  localparam int POS_W       = 24;
  localparam int DIFF_W      = 25;
  localparam int FACE_W      = 51;
  localparam int SUM_W       = 53;
  localparam int NORM_W      = 16;
  localparam int IDX_W       = 10;

  // normalizer datapath
  localparam int UNIT_W      = 30;
  localparam int SQ_W        = 60;
  localparam int L2_W        = 62;
  localparam int ROOT_W      = 64;
  localparam int ROOT_TOP    = 62;
  localparam int LEN_W       = 31;
  localparam int FRAC_SH     = 14;
  localparam int NUM_W       = 45;
  localparam int QUO_W       = 15;
  localparam int REM_W       = 32;

  typedef logic signed [SUM_W-1:0]  sum_t;
  typedef logic signed [NORM_W-1:0] norm_t;

  typedef struct packed {
    logic start;
    sum_t x;
    sum_t y;
    sum_t z;
  } norm_req_t;

  typedef struct packed {
    logic  done;
    logic  zero;
    norm_t x;
    norm_t y;
    norm_t z;
  } norm_res_t;

  // next lane in x -> y -> z -> x order
  function automatic int nxt3(input int k);
    return (k == 2) ? 0 : k + 1;
  endfunction

endpackage
`default_nettype wire

[hw/rtl/grid_vertex_normal_averager.sv]
// ----------------------------------------------------------------------------
// grid_vertex_normal_averager: vertex normals of a square height-map grid
// Usage notes:
//   Input words carry one vertex each (in_pos_x/y/z), row-major, and are taken
//   when in_valid is high and in_stall is low. in_stall is high while a word
//   is being worked on. Result words leave on out_* under out_valid/out_stall.
//   cfg_wr_en writes the grid width and restarts the grid at row 0, column 0;
//   write it only while the block is idle.
//   Row 0 words give no result. Later words give the normal of the vertex
//   above them; words of the last row give a second word, their own normal.
//   The time per word depends on the row. On later rows it is set by the
//   bit-serial cross product (two passes), then per normal by the serial
//   squares, square root and dividers of the shared normalizer.
//   A stalled receiver holds the finished word in the output register; the
//   block then waits before loading the next result word.
//   Reset clears counters and valid and sets the width to 257; the row memories need no
//   clearing since every read follows a write within the grid.
// ----------------------------------------------------------------------------
`default_nettype none
module grid_vertex_normal_averager #(
  parameter int MAX_ROW = gvna_pkg::DEF_MAX_ROW
) (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire                      cfg_wr_en,
  input  wire [10:0]               cfg_wr_data,
  input  wire                      in_valid,
  output logic                     in_stall,
  input  wire signed [23:0]        in_pos_x,
  input  wire signed [23:0]        in_pos_y,
  input  wire signed [23:0]        in_pos_z,
  output logic                     out_valid,
  input  wire                      out_stall,
  output logic signed [15:0]       out_normal_x,
  output logic signed [15:0]       out_normal_y,
  output logic signed [15:0]       out_normal_z,
  output logic [9:0]               out_vertex_row,
  output logic [9:0]               out_vertex_col,
  output logic                     out_zero_length,
  output logic                     out_last_of_run
);

  localparam int ADDR_W = $clog2(MAX_ROW);
  localparam int WW     = $clog2(MAX_ROW + 1);
  localparam int CFG_W  = gvna_pkg::CFG_W;
  localparam int CW     = (WW > CFG_W) ? WW : CFG_W;
  localparam int POS_W  = gvna_pkg::POS_W;
  localparam int DIFF_W = gvna_pkg::DIFF_W;
  localparam int FACE_W = gvna_pkg::FACE_W;
  localparam int SUM_W  = gvna_pkg::SUM_W;
  localparam int IDX_W  = gvna_pkg::IDX_W;
  localparam logic [4:0] STEP_LAST = 5'(DIFF_W - 1);

  typedef enum logic [3:0] {
    S_IDLE, S_RD0, S_RD1, S_RD2, S_LD, S_MUL, S_SUM,
    S_N1, S_W1, S_O1, S_N2, S_W2, S_O2, S_UPD
  } state_t;

  state_t                     state_r;
  logic [CFG_W-1:0]           grid_width_r;
  logic [ADDR_W-1:0]          col_r;
  logic [ADDR_W-1:0]          row_r;
  logic signed [POS_W-1:0]    p_r     [3];
  logic signed [POS_W-1:0]    pc_r    [3];
  logic signed [FACE_W-1:0]   fc_r    [3];
  logic signed [DIFF_W-1:0]   a_r     [3];
  logic signed [DIFF_W-1:0]   b_r     [3];
  logic signed [FACE_W-1:0]   mc_r    [3];
  logic [DIFF_W-1:0]          mb_r    [3];
  logic signed [FACE_W-1:0]   acc_r   [3];
  logic [4:0]                 step_r;
  logic                       pass_r;
  logic [1:0]                 term_r;
  gvna_pkg::sum_t             s1_r    [3];
  gvna_pkg::sum_t             s2_r    [3];
  logic signed [FACE_W-1:0]   lh_old_r [3];
  logic signed [FACE_W-1:0]   lh_new_r [3];

  logic [3*POS_W-1:0]         prev_mem [MAX_ROW];
  logic [3*FACE_W-1:0]        face_mem [MAX_ROW];
  logic [3*POS_W-1:0]         prev_q;
  logic [3*FACE_W-1:0]        face_q;

  logic [CW-1:0]              cfg_ext;
  logic [WW-1:0]              weff;
  logic [WW:0]                col_p1;
  logic [WW:0]                row_p1;
  logic                       has_new;
  logic                       last_row;
  logic                       row_ge2;
  logic                       col_ge1;
  logic [ADDR_W-1:0]          rd_addr;
  logic                       slot_free;
  logic                       face_we;
  logic [ADDR_W-1:0]          row_m1;
  logic signed [FACE_W-1:0]   term_v  [3];
  logic [3*FACE_W-1:0]        face_wd;

  gvna_pkg::norm_req_t        norm_req;
  gvna_pkg::norm_res_t        norm_res;

  always_comb begin
    cfg_ext = CW'(grid_width_r);
    if (cfg_ext < CW'(2)) begin
      weff = WW'(2);
    end else if (cfg_ext > CW'(MAX_ROW)) begin
      weff = WW'(MAX_ROW);
    end else begin
      weff = WW'(cfg_ext);
    end
    col_p1   = (WW+1)'(col_r) + (WW+1)'(1);
    row_p1   = (WW+1)'(row_r) + (WW+1)'(1);
    has_new  = (col_p1 < (WW+1)'(weff));
    last_row = (row_p1 == (WW+1)'(weff));
    row_ge2  = (WW'(row_r) >= WW'(2));
    col_ge1  = (col_r != '0);
    row_m1   = row_r - ADDR_W'(1);
    rd_addr  = (state_r == S_RD1) ? col_r + ADDR_W'(1) : col_r;
    slot_free = !out_valid || !out_stall;
    face_we  = (state_r == S_UPD) && (row_r != '0) && has_new;
    in_stall = (state_r != S_IDLE);
    for (int k = 0; k < 3; k++) begin
      face_wd[k*FACE_W +: FACE_W] = acc_r[k];
      case (term_r)
        2'd0:    term_v[k] = (row_ge2 && col_ge1) ? lh_old_r[k] : '0;
        2'd1:    term_v[k] = (row_ge2 && has_new) ? fc_r[k] : '0;
        2'd2:    term_v[k] = col_ge1 ? lh_new_r[k] : '0;
        default: term_v[k] = has_new ? acc_r[k] : '0;
      endcase
    end
    norm_req.start = (state_r == S_N1) || (state_r == S_N2);
    norm_req.x = (state_r == S_N2) ? s2_r[0] : s1_r[0];
    norm_req.y = (state_r == S_N2) ? s2_r[1] : s1_r[1];
    norm_req.z = (state_r == S_N2) ? s2_r[2] : s1_r[2];
  end

  // row memories: latest vertex and latest face normal of each column
  always_ff @(posedge clk) begin
    if (state_r == S_UPD) begin
      prev_mem[col_r] <= {p_r[2], p_r[1], p_r[0]};
    end
    if (face_we) begin
      face_mem[col_r] <= face_wd;
    end
    prev_q <= prev_mem[rd_addr];
    face_q <= face_mem[col_r];
  end

  gvna_norm u_norm (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (norm_req),
    .res   (norm_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      grid_width_r <= CFG_W'(gvna_pkg::GRID_RESET);
      col_r        <= '0;
      row_r        <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            p_r[0] <= in_pos_x;
            p_r[1] <= in_pos_y;
            p_r[2] <= in_pos_z;
            for (int k = 0; k < 3; k++) begin
              acc_r[k] <= '0;
              s1_r[k]  <= '0;
              s2_r[k]  <= '0;
            end
            state_r <= (row_r == '0) ? S_UPD : S_RD0;
          end
        end
        S_RD0: state_r <= S_RD1;
        S_RD1: begin
          for (int k = 0; k < 3; k++) begin
            pc_r[k] <= prev_q[k*POS_W +: POS_W];
            fc_r[k] <= face_q[k*FACE_W +: FACE_W];
          end
          term_r  <= '0;
          state_r <= has_new ? S_RD2 : S_SUM;
        end
        S_RD2: begin
          for (int k = 0; k < 3; k++) begin
            a_r[k] <= DIFF_W'(pc_r[k]) - DIFF_W'(p_r[k]);
            b_r[k] <= DIFF_W'(p_r[k]) - DIFF_W'($signed(prev_q[k*POS_W +: POS_W]));
          end
          state_r <= S_LD;
        end
        S_LD: begin
          for (int k = 0; k < 3; k++) begin
            mc_r[k] <= FACE_W'(a_r[gvna_pkg::nxt3(k)]);
            mb_r[k] <= $unsigned(b_r[gvna_pkg::nxt3(gvna_pkg::nxt3(k))]);
          end
          step_r  <= '0;
          pass_r  <= 1'b0;
          state_r <= S_MUL;
        end
        S_MUL: begin
          // first pass adds, second pass subtracts; the sign bit weighs negative
          for (int k = 0; k < 3; k++) begin
            if (mb_r[k][0]) begin
              if ((step_r == STEP_LAST) ^ pass_r) acc_r[k] <= acc_r[k] - mc_r[k];
              else acc_r[k] <= acc_r[k] + mc_r[k];
            end
            mc_r[k] <= mc_r[k] << 1;
            mb_r[k] <= mb_r[k] >> 1;
          end
          step_r <= step_r + 5'd1;
          if (step_r == STEP_LAST) begin
            if (!pass_r) begin
              for (int k = 0; k < 3; k++) begin
                mc_r[k] <= FACE_W'(a_r[gvna_pkg::nxt3(gvna_pkg::nxt3(k))]);
                mb_r[k] <= $unsigned(b_r[gvna_pkg::nxt3(k)]);
              end
              step_r <= '0;
              pass_r <= 1'b1;
            end else begin
              term_r  <= '0;
              state_r <= S_SUM;
            end
          end
        end
        S_SUM: begin
          // both sums share the newer face row terms
          for (int k = 0; k < 3; k++) begin
            s1_r[k] <= s1_r[k] + SUM_W'(term_v[k]);
            if (term_r[1]) s2_r[k] <= s2_r[k] + SUM_W'(term_v[k]);
          end
          term_r <= term_r + 2'd1;
          if (term_r == 2'd3) state_r <= S_N1;
        end
        S_N1: state_r <= S_W1;
        S_W1: if (norm_res.done) state_r <= S_O1;
        S_O1: begin
          if (slot_free) begin
            out_valid       <= 1'b1;
            out_normal_x    <= norm_res.x;
            out_normal_y    <= norm_res.y;
            out_normal_z    <= norm_res.z;
            out_zero_length <= norm_res.zero;
            out_vertex_row  <= IDX_W'(row_m1);
            out_vertex_col  <= IDX_W'(col_r);
            out_last_of_run <= !last_row;
            state_r         <= last_row ? S_N2 : S_UPD;
          end
        end
        S_N2: state_r <= S_W2;
        S_W2: if (norm_res.done) state_r <= S_O2;
        S_O2: begin
          if (slot_free) begin
            out_valid       <= 1'b1;
            out_normal_x    <= norm_res.x;
            out_normal_y    <= norm_res.y;
            out_normal_z    <= norm_res.z;
            out_zero_length <= norm_res.zero;
            out_vertex_row  <= IDX_W'(row_r);
            out_vertex_col  <= IDX_W'(col_r);
            out_last_of_run <= 1'b1;
            state_r         <= S_UPD;
          end
        end
        S_UPD: begin
          if (row_r != '0 && has_new) begin
            lh_old_r <= fc_r;
            lh_new_r <= acc_r;
          end
          if (has_new) begin
            col_r <= col_r + ADDR_W'(1);
          end else begin
            col_r <= '0;
            row_r <= last_row ? '0 : row_r + ADDR_W'(1);
          end
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
      // a width write restarts the grid
      if (cfg_wr_en) begin
        grid_width_r <= cfg_wr_data;
        col_r        <= '0;
        row_r        <= '0;
      end
    end
  end

  a_done_while_waiting: assert property (@(posedge clk) disable iff (!rst_n)
    norm_res.done |-> (state_r == S_W1 || state_r == S_W2))
    else $error("normalizer finished while no result was awaited");

  a_cfg_restarts_grid: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_wr_en |=> (col_r == '0 && row_r == '0))
    else $error("width write did not restart the grid");

  a_zero_flag_zero_normal: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_zero_length) |->
      (out_normal_x == '0 && out_normal_y == '0 && out_normal_z == '0))
    else $error("zero length word carries a nonzero normal");

endmodule
`default_nettype wire

[hw/rtl/gvna_norm.sv]
// ----------------------------------------------------------------------------
// gvna_norm: bit-serial vector normalizer
// Scales a summed normal to Q1.14: align shift, serial squares, digit-by-digit
// square root and three restoring dividers, one bit per cycle per lane.
// ----------------------------------------------------------------------------
`default_nettype none
module gvna_norm (
  input  wire                   clk,
  input  wire                   rst_n,
  input  var gvna_pkg::norm_req_t req,
  output gvna_pkg::norm_res_t   res
);

  localparam int SUM_W  = gvna_pkg::SUM_W;
  localparam int UNIT_W = gvna_pkg::UNIT_W;
  localparam int SQ_W   = gvna_pkg::SQ_W;
  localparam int L2_W   = gvna_pkg::L2_W;
  localparam int ROOT_W = gvna_pkg::ROOT_W;
  localparam int LEN_W  = gvna_pkg::LEN_W;
  localparam int NUM_W  = gvna_pkg::NUM_W;
  localparam int QUO_W  = gvna_pkg::QUO_W;
  localparam int REM_W  = gvna_pkg::REM_W;
  localparam int NORM_W = gvna_pkg::NORM_W;
  localparam int TOP_BIT = UNIT_W - 1;
  localparam int FAR_BIT = TOP_BIT + 9;
  localparam int LOW_BIT = TOP_BIT - 8;

  typedef enum logic [2:0] {
    N_IDLE, N_SHIFT, N_SQ, N_ADD1, N_ADD2, N_SQRT, N_DIVLD, N_DIV
  } nstate_t;

  nstate_t              state_r;
  logic [SUM_W-1:0]     u_r   [3];
  logic [2:0]           neg_r;
  logic [SQ_W-1:0]      mc_r  [3];
  logic [UNIT_W-1:0]    mb_r  [3];
  logic [SQ_W-1:0]      q_r   [3];
  logic [4:0]           cnt_r;
  logic [L2_W-1:0]      l2_r;
  logic [ROOT_W-1:0]    x_r;
  logic [ROOT_W-1:0]    root_r;
  logic [ROOT_W-1:0]    bit_r;
  logic [REM_W-1:0]     rem_r [3];
  logic [QUO_W-1:0]     nb_r  [3];
  logic [QUO_W-1:0]     quo_r [3];

  gvna_pkg::sum_t       s_in  [3];
  logic [SUM_W-1:0]     or_v;
  logic [LEN_W-1:0]     len;
  logic [NUM_W-1:0]     num   [3];
  logic [REM_W-1:0]     trial [3];
  logic [2:0]           ge;
  logic [QUO_W-1:0]     quo_n [3];
  logic [ROOT_W-1:0]    root_try;
  gvna_pkg::norm_t      nrm   [3];

  always_comb begin
    s_in[0] = req.x;
    s_in[1] = req.y;
    s_in[2] = req.z;
    or_v = u_r[0] | u_r[1] | u_r[2];
    len = root_r[LEN_W-1:0];
    root_try = root_r + bit_r;
    for (int k = 0; k < 3; k++) begin
      num[k] = (NUM_W'(u_r[k][UNIT_W-1:0]) << gvna_pkg::FRAC_SH) + NUM_W'(len >> 1);
      trial[k] = {rem_r[k][REM_W-2:0], nb_r[k][QUO_W-1]};
      ge[k] = (trial[k] >= REM_W'(len));
      quo_n[k] = {quo_r[k][QUO_W-2:0], ge[k]};
      nrm[k] = neg_r[k] ? NORM_W'(0) - NORM_W'(quo_n[k]) : NORM_W'(quo_n[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= N_IDLE;
      res.done <= 1'b0;
    end else begin
      res.done <= 1'b0;
      case (state_r)
        N_IDLE: begin
          if (req.start) begin
            for (int k = 0; k < 3; k++) begin
              neg_r[k] <= s_in[k][SUM_W-1];
              u_r[k] <= s_in[k][SUM_W-1] ? $unsigned(-s_in[k]) : $unsigned(s_in[k]);
            end
            if (s_in[0] == '0 && s_in[1] == '0 && s_in[2] == '0) begin
              res.done <= 1'b1;
              res.zero <= 1'b1;
              res.x    <= '0;
              res.y    <= '0;
              res.z    <= '0;
            end else begin
              state_r <= N_SHIFT;
            end
          end
        end
        N_SHIFT: begin
          // align the largest magnitude to bit TOP_BIT
          if (|or_v[SUM_W-1:FAR_BIT]) begin
            for (int k = 0; k < 3; k++) u_r[k] <= u_r[k] >> 8;
          end else if (|or_v[SUM_W-1:TOP_BIT+1]) begin
            for (int k = 0; k < 3; k++) u_r[k] <= u_r[k] >> 1;
          end else if (or_v[SUM_W-1:LOW_BIT] == '0) begin
            for (int k = 0; k < 3; k++) u_r[k] <= u_r[k] << 8;
          end else if (!or_v[TOP_BIT]) begin
            for (int k = 0; k < 3; k++) u_r[k] <= u_r[k] << 1;
          end else begin
            for (int k = 0; k < 3; k++) begin
              mc_r[k] <= SQ_W'(u_r[k][UNIT_W-1:0]);
              mb_r[k] <= u_r[k][UNIT_W-1:0];
              q_r[k]  <= '0;
            end
            cnt_r   <= '0;
            state_r <= N_SQ;
          end
        end
        N_SQ: begin
          for (int k = 0; k < 3; k++) begin
            if (mb_r[k][0]) q_r[k] <= q_r[k] + mc_r[k];
            mc_r[k] <= mc_r[k] << 1;
            mb_r[k] <= mb_r[k] >> 1;
          end
          cnt_r <= cnt_r + 5'd1;
          if (cnt_r == 5'(UNIT_W-1)) state_r <= N_ADD1;
        end
        N_ADD1: begin
          l2_r    <= L2_W'(q_r[0]) + L2_W'(q_r[1]);
          state_r <= N_ADD2;
        end
        N_ADD2: begin
          x_r     <= ROOT_W'(l2_r + L2_W'(q_r[2]));
          root_r  <= '0;
          bit_r   <= ROOT_W'(1) << gvna_pkg::ROOT_TOP;
          state_r <= N_SQRT;
        end
        N_SQRT: begin
          if (bit_r == '0) begin
            state_r <= N_DIVLD;
          end else begin
            if (x_r >= root_try) begin
              x_r    <= x_r - root_try;
              root_r <= (root_r >> 1) + bit_r;
            end else begin
              root_r <= root_r >> 1;
            end
            bit_r <= bit_r >> 2;
          end
        end
        N_DIVLD: begin
          for (int k = 0; k < 3; k++) begin
            rem_r[k] <= REM_W'(num[k] >> QUO_W);
            nb_r[k]  <= num[k][QUO_W-1:0];
            quo_r[k] <= '0;
          end
          cnt_r   <= '0;
          state_r <= N_DIV;
        end
        N_DIV: begin
          for (int k = 0; k < 3; k++) begin
            rem_r[k] <= ge[k] ? trial[k] - REM_W'(len) : trial[k];
            nb_r[k]  <= nb_r[k] << 1;
            quo_r[k] <= quo_n[k];
          end
          cnt_r <= cnt_r + 5'd1;
          if (cnt_r == 5'(QUO_W-1)) begin
            res.done <= 1'b1;
            res.zero <= 1'b0;
            res.x    <= nrm[0];
            res.y    <= nrm[1];
            res.z    <= nrm[2];
            state_r  <= N_IDLE;
          end
        end
        default: state_r <= N_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

[sim/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top: testbench for grid_vertex_normal_averager
// Streams height-map grids of several widths through the block with random
// gaps and output stalls. A scoreboard object predicts every vertex normal
// word and checks the result words in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

typedef struct {
  logic signed [15:0] nx;
  logic signed [15:0] ny;
  logic signed [15:0] nz;
  logic [9:0]         vrow;
  logic [9:0]         vcol;
  logic               zero_len;
  logic               last;
} normal_word_t;

class normal_scoreboard;
  longint vert_x[1024], vert_y[1024], vert_z[1024];
  longint face_x[1024], face_y[1024], face_z[1024];
  longint left_face[6];
  int unsigned width_reg;
  int unsigned col_cnt, row_cnt;
  normal_word_t expected_normals[$];
  int errors;

  function new();
    width_reg = gvna_pkg::GRID_RESET;
    col_cnt = 0;
    row_cnt = 0;
    errors = 0;
  endfunction

  function void set_width(logic [10:0] value);
    width_reg = value;
    col_cnt = 0;
    row_cnt = 0;
  endfunction

  function int pending();
    return expected_normals.size();
  endfunction

  function longint unsigned int_sqrt(longint unsigned x);
    longint unsigned r, bitv;
    r = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv >>= 2;
    while (bitv != 0) begin
      if (x >= r + bitv) begin
        x -= r + bitv;
        r = (r >> 1) + bitv;
      end else begin
        r >>= 1;
      end
      bitv >>= 2;
    end
    return r;
  endfunction

  // normalize the summed face normals to Q1.14
  function normal_word_t make_normal(longint s[3], int unsigned r, int unsigned c, bit last);
    normal_word_t w;
    longint unsigned u[3], m, l2, len, n;
    int p;
    m = 0;
    l2 = 0;
    p = 0;
    for (int k = 0; k < 3; k++) begin
      u[k] = (s[k] < 0) ? -s[k] : s[k];
      if (u[k] > m) m = u[k];
    end
    w.vrow = r[9:0];
    w.vcol = c[9:0];
    w.last = last;
    if (m == 0) begin
      w.nx = 0;
      w.ny = 0;
      w.nz = 0;
      w.zero_len = 1'b1;
      return w;
    end
    while (p < 63 && (m >> (p + 1)) != 0) p++;
    for (int k = 0; k < 3; k++) begin
      if (p > 29) u[k] >>= (p - 29);
      else u[k] <<= (29 - p);
      l2 += u[k] * u[k];
    end
    len = int_sqrt(l2);
    for (int k = 0; k < 3; k++) begin
      n = (u[k] * 16384 + (len >> 1)) / len;
      if (s[k] < 0) n = -n;
      if (k == 0) w.nx = n[15:0];
      else if (k == 1) w.ny = n[15:0];
      else w.nz = n[15:0];
    end
    w.zero_len = 1'b0;
    return w;
  endfunction

  function void note_input(logic signed [23:0] in_x, logic signed [23:0] in_y,
                           logic signed [23:0] in_z);
    int unsigned w, r, c;
    longint px, py, pz, ax, ay, az, bx, by, bz;
    longint nf[3], s[3];
    bit has_new;
    w = width_reg;
    r = row_cnt;
    c = col_cnt;
    px = in_x;
    py = in_y;
    pz = in_z;
    if (w < 2) w = 2;
    if (w > 1024) w = 1024;
    if (r >= w || c >= w) begin
      r = 0;
      c = 0;
    end
    if (r >= 1) begin
      has_new = (c + 1 < w);
      nf = '{0, 0, 0};
      if (has_new) begin
        ax = vert_x[c] - px;
        ay = vert_y[c] - py;
        az = vert_z[c] - pz;
        bx = px - vert_x[c+1];
        by = py - vert_y[c+1];
        bz = pz - vert_z[c+1];
        nf[0] = ay * bz - az * by;
        nf[1] = az * bx - ax * bz;
        nf[2] = ax * by - ay * bx;
      end
      s = '{0, 0, 0};
      for (int k = 0; k < 3; k++) begin
        if (r >= 2 && c >= 1) s[k] += left_face[k];
        if (r >= 2 && has_new) s[k] += (k == 0) ? face_x[c] : (k == 1) ? face_y[c] : face_z[c];
        if (c >= 1) s[k] += left_face[k+3];
        if (has_new) s[k] += nf[k];
      end
      expected_normals.push_back(make_normal(s, r - 1, c, r + 1 != w));
      if (r + 1 == w) begin
        // last row: own normal from the newer faces only
        s = '{0, 0, 0};
        for (int k = 0; k < 3; k++) begin
          if (c >= 1) s[k] += left_face[k+3];
          if (has_new) s[k] += nf[k];
        end
        expected_normals.push_back(make_normal(s, r, c, 1'b1));
      end
      if (has_new) begin
        left_face[0] = face_x[c];
        left_face[1] = face_y[c];
        left_face[2] = face_z[c];
        face_x[c] = nf[0];
        face_y[c] = nf[1];
        face_z[c] = nf[2];
        for (int k = 0; k < 3; k++) left_face[k+3] = nf[k];
      end
    end
    vert_x[c] = px;
    vert_y[c] = py;
    vert_z[c] = pz;
    c++;
    if (c >= w) begin
      c = 0;
      r++;
      if (r >= w) r = 0;
    end
    col_cnt = c;
    row_cnt = r;
  endfunction

  function void check(normal_word_t got);
    normal_word_t want;
    if (expected_normals.size() == 0) begin
      errors++;
      if (errors <= 10)
        $display("unexpected word: row %0d col %0d", got.vrow, got.vcol);
      return;
    end
    want = expected_normals.pop_front();
    if (got.nx !== want.nx || got.ny !== want.ny || got.nz !== want.nz ||
        got.vrow !== want.vrow || got.vcol !== want.vcol ||
        got.zero_len !== want.zero_len || got.last !== want.last) begin
      errors++;
      if (errors <= 10) begin
        $display("mismatch: exp n=(%0d,%0d,%0d) rc=(%0d,%0d) z=%0b l=%0b",
                 want.nx, want.ny, want.nz, want.vrow, want.vcol, want.zero_len,
                 want.last);
        $display("          got n=(%0d,%0d,%0d) rc=(%0d,%0d) z=%0b l=%0b",
                 got.nx, got.ny, got.nz, got.vrow, got.vcol, got.zero_len,
                 got.last);
      end
    end
  endfunction
endclass

module tb_top;
  localparam longint CYCLE_LIMIT = 4000000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_wr_en = 1'b0;
  logic [10:0] cfg_wr_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [23:0] in_pos_x = '0, in_pos_y = '0, in_pos_z = '0;
  logic out_valid;
  logic out_stall = 1'b1;
  logic signed [15:0] out_normal_x, out_normal_y, out_normal_z;
  logic [9:0] out_vertex_row, out_vertex_col;
  logic out_zero_length, out_last_of_run;

  normal_scoreboard sb = new();
  longint cycles = 0;
  bit no_idle = 1'b0;
  bit word_taken = 1'b0;
  int stall_left = 0;
  int unsigned gen_row, gen_col, gen_w;

  grid_vertex_normal_averager u_dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_pos_x(in_pos_x), .in_pos_y(in_pos_y), .in_pos_z(in_pos_z),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_normal_x(out_normal_x), .out_normal_y(out_normal_y),
    .out_normal_z(out_normal_z),
    .out_vertex_row(out_vertex_row), .out_vertex_col(out_vertex_col),
    .out_zero_length(out_zero_length), .out_last_of_run(out_last_of_run)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    normal_word_t got;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
    word_taken = 1'b0;
    if (rst_n && out_valid && !out_stall) begin
      got.nx = out_normal_x;
      got.ny = out_normal_y;
      got.nz = out_normal_z;
      got.vrow = out_vertex_row;
      got.vcol = out_vertex_col;
      got.zero_len = out_zero_length;
      got.last = out_last_of_run;
      sb.check(got);
      word_taken = 1'b1;
    end
  end

  // draw a fresh stall length after every accepted result word
  always @(negedge clk) begin
    if (word_taken) stall_left = no_idle ? 0 : $urandom_range(0, 8);
    if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic send_vertex(logic signed [23:0] vx, logic signed [23:0] vy,
                             logic signed [23:0] vz);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_pos_x <= vx;
    in_pos_y <= vy;
    in_pos_z <= vz;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    sb.note_input(vx, vy, vz);
    @(negedge clk);
    gen_col++;
    if (gen_col >= gen_w) begin
      gen_col = 0;
      gen_row++;
    end
  endtask

  // hold until every word is out and a row-0 word has had time to finish
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() > 0) @(posedge clk);
    repeat (400) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_width(logic [10:0] value);
    drain();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    sb.set_width(value);
    cfg_wr_en <= 1'b0;
    gen_w = (value < 2) ? 2 : (value > 1024) ? 1024 : value;
    gen_row = 0;
    gen_col = 0;
    no_idle = ($urandom_range(0, 4) == 0);
  endtask

  // vertex styles: 0 full range, 1 terrain, 2 flat, 3 extremes
  task automatic send_styled(int style);
    logic signed [23:0] vx, vy, vz;
    case (style)
      0: begin
        vx = 24'($urandom);
        vy = 24'($urandom);
        vz = 24'($urandom);
      end
      1: begin
        vx = 24'($signed(gen_col * 256 + $urandom_range(0, 64)) - 32);
        vz = 24'($signed(gen_row * 256 + $urandom_range(0, 64)) - 32);
        vy = 24'($signed($urandom_range(0, 4095)) - 2048);
      end
      2: begin
        vx = 24'sd1000;
        vy = 24'sd1000;
        vz = 24'sd1000;
      end
      default: begin
        vx = $urandom_range(0, 1) ? 24'sh7FFFFF : 24'sh800000;
        vy = $urandom_range(0, 1) ? 24'sh7FFFFF : 24'sh800000;
        vz = $urandom_range(0, 1) ? 24'sh7FFFFF : 24'sh800000;
      end
    endcase
    send_vertex(vx, vy, vz);
  endtask

  task automatic send_grid(int count, int style);
    for (int i = 0; i < count; i++) send_styled(style);
  endtask

  initial begin
    int w, count, sent, style;
    gen_w = gvna_pkg::GRID_RESET;
    gen_row = 0;
    gen_col = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset width: row 0 runs result-free, then a few normals of row 0
    send_grid(gvna_pkg::GRID_RESET + 3, 1);

    write_width(11'd2);
    send_grid(4, 3);
    send_vertex(24'sh7FFFFF, 24'sh800000, 24'sh7FFFFF);
    send_vertex(24'sh800000, 24'sh7FFFFF, 24'sh800000);
    send_vertex(24'sh000000, 24'sh7FFFFF, 24'sh800000);
    send_vertex(24'sh7FFFFF, 24'sh000000, 24'shFFFFFF);
    write_width(11'd3);
    send_grid(9, 2);
    write_width(11'd0);
    send_grid(4, 0);
    write_width(11'd1);
    send_grid(5, 1);

    // random grids; an occasional partial grid before the restart
    sent = 0;
    while (sent < 600) begin
      case ($urandom_range(0, 9))
        0: w = $urandom_range(0, 1);
        1: w = $urandom_range(9, 16);
        default: w = $urandom_range(2, 8);
      endcase
      write_width(11'(w));
      if (w < 2) w = 2;
      count = w * w * $urandom_range(1, 2);
      if ($urandom_range(0, 3) == 0) count += $urandom_range(1, w * w - 1);
      style = $urandom_range(0, 9);
      style = (style < 4) ? 0 : (style < 8) ? 1 : (style == 8) ? 2 : 3;
      send_grid(count, style);
      sent += count;
    end

    // oversized width: a partial first row stays result-free
    write_width(11'd2047);
    send_grid(20, 1);
    write_width(11'd5);
    send_grid(25, 0);

    drain();
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
